// ===== src/cit_pkg.sv =====
// Shared types and codes for the cache index table.
package cit_pkg;

    typedef enum logic [1:0] {
        OP_STORE      = 2'd0,
        OP_FETCH      = 2'd1,
        OP_INVALIDATE = 2'd2,
        OP_NONE       = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_BYTE_LIMIT    = 2'd0,
        CFG_EVICT_MARGIN  = 2'd1,
        CFG_ADDRESS_BITS  = 2'd2,
        CFG_CAPACITY_BITS = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RESP,
        S_LK0, S_LK1, S_LK2, S_LK3,
        S_EV_CHECK, S_EV_HEAD, S_SCAN, S_SCAN_END, S_EV_EMIT,
        S_RM0, S_RM1, S_RM2, S_RM3, S_RM_DONE,
        S_INS0, S_INS1, S_INS2, S_INS3
    } t_state;

    localparam int TOTAL_W = 44;
    localparam int CFG_W   = 44;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] data_bytes;
        logic [31:0] meta_bytes;
        logic [15:0] uses;
        logic [31:0] stamp;
    } t_rec;

    typedef struct packed {
        logic        kind;
        logic        status;
        logic [31:0] key_out;
        logic [9:0]  slot;
        logic [31:0] data_bytes;
        logic [31:0] meta_bytes;
        logic [15:0] uses;
        logic        evict_capped;
        logic        last;
    } t_res;

    // Replacement order: fewer uses, then older stamp, then smaller key.
    function automatic logic rec_less(input t_rec a, input t_rec b);
        rec_less = (a.uses < b.uses) ||
                   (a.uses == b.uses && (a.stamp < b.stamp ||
                                         (a.stamp == b.stamp && a.key < b.key)));
    endfunction

endpackage

// ===== src/cit_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
module cit_ram #(
    parameter int W = 8,
    parameter int A = 4
) (
    input  logic         i_clk,
    input  logic         i_we,
    input  logic [A-1:0] i_waddr,
    input  logic [W-1:0] i_wdata,
    input  logic [A-1:0] i_raddr,
    output logic [W-1:0] o_rdata
);
    logic [W-1:0] r_mem [2**A];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/cache_index_table_with_lfu_eviction_core.sv =====
// Answers: an unknown operation goes straight to a response; fetch/invalidate look up the map
// and then the slot (an invalidate hit then removes the entry); a store answers after eviction.
// Each eviction scans live slots at one read per cycle, up to EVICT_MAX evictions
// per store; output stalls delay every answer and eviction notice.
// Throughput: one item at a time, bounded by the single slot RAM read port.
// Reset: synchronous, then every map cell is cleared with no item taken.
module cache_index_table_with_lfu_eviction_core #(
    parameter int ADDR_BITS  = 12,
    parameter int SLOT_BITS  = 10,
    parameter int EVICT_MAX  = 63
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_operation,
    input  logic [31:0]               i_key,
    input  logic                      i_is_meta,
    input  logic [31:0]               i_length,
    input  logic [31:0]               i_now,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_kind,
    output logic                      o_status,
    output logic [31:0]               o_key_out,
    output logic [9:0]                o_slot,
    output logic [31:0]               o_data_bytes,
    output logic [31:0]               o_meta_bytes,
    output logic [15:0]               o_uses,
    output logic                      o_evict_capped,
    output logic                      o_last,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [cit_pkg::CFG_W-1:0] i_cfg_data
);
    import cit_pkg::*;

    localparam int AW = ADDR_BITS;
    localparam int EB = SLOT_BITS;

    t_state r_state, n_state;

    logic [TOTAL_W-1:0] r_byte_limit, r_evict_margin, r_total, n_total;
    logic [3:0]         r_address_bits, r_capacity_bits;
    logic [EB:0]        r_nfs, n_nfs;
    logic [AW-1:0]      r_clr, n_clr;

    t_op         r_op, n_op;
    logic [31:0] r_key, n_key, r_len, n_len, r_now, n_now;
    logic        r_meta, n_meta;

    logic [EB:0]        r_idx, n_idx;
    logic [EB-1:0]      r_pidx, n_pidx;
    logic               r_pv, n_pv;
    logic [EB-1:0]      r_s, n_s;
    t_rec               r_srec, n_srec, r_lrec, n_lrec;
    logic [5:0]         r_count, n_count;
    logic [TOTAL_W-1:0] r_removed, n_removed;
    logic               r_capped, n_capped, r_rep, n_rep, r_evict, n_evict;

    logic r_ov;
    t_res r_res, n_res;
    logic n_emit, out_free;

    logic          map_we;
    logic [AW-1:0] map_waddr, map_raddr;
    logic [EB-1:0] map_wdata, map_rdata;
    logic          slot_we;
    logic [EB-1:0] slot_waddr, slot_raddr;
    t_rec          slot_wdata, slot_rdata;

    logic [4:0]    asat, csat;
    logic [AW-1:0] amask, a_key, a_skey, a_lkey;
    logic [EB:0]   full_lim;
    logic [EB-1:0] last_slot;
    logic          map_hit, better;
    t_rec          upd;
    logic [15:0]   s_wide;

    cit_ram #(.W(EB), .A(AW)) u_map (
        .i_clk(i_clk), .i_we(map_we), .i_waddr(map_waddr), .i_wdata(map_wdata),
        .i_raddr(map_raddr), .o_rdata(map_rdata)
    );

    cit_ram #(.W($bits(t_rec)), .A(EB)) u_slot (
        .i_clk(i_clk), .i_we(slot_we), .i_waddr(slot_waddr), .i_wdata(slot_wdata),
        .i_raddr(slot_raddr), .o_rdata(slot_rdata)
    );

    // Saturate the range registers.
    assign asat = (r_address_bits == 4'd0) ? 5'd1 :
                  ({1'b0, r_address_bits} > 5'(AW)) ? 5'(AW) : {1'b0, r_address_bits};
    assign csat = (r_capacity_bits == 4'd0) ? 5'd1 :
                  ({1'b0, r_capacity_bits} > 5'(EB)) ? 5'(EB) : {1'b0, r_capacity_bits};
    assign amask    = ~({AW{1'b1}} << asat);
    assign full_lim = (EB+1)'(1) << csat;
    assign a_key    = r_key[AW-1:0] & amask;
    assign a_skey   = r_srec.key[AW-1:0] & amask;
    assign a_lkey   = r_lrec.key[AW-1:0] & amask;
    assign last_slot = r_nfs[EB-1:0] - EB'(1);
    assign map_hit  = (map_rdata != '0) && ({1'b0, map_rdata} < r_nfs);
    assign better   = (r_pidx == EB'(1)) || rec_less(slot_rdata, r_srec);
    assign s_wide   = 16'(r_s);
    assign out_free = !r_ov || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_total = r_total; n_nfs = r_nfs; n_clr = r_clr;
        n_op = r_op; n_key = r_key; n_len = r_len; n_now = r_now; n_meta = r_meta;
        n_idx = r_idx; n_pidx = r_pidx; n_pv = r_pv; n_s = r_s;
        n_srec = r_srec; n_lrec = r_lrec; n_count = r_count; n_removed = r_removed;
        n_capped = r_capped; n_rep = r_rep; n_evict = r_evict;
        n_emit = 1'b0; n_res = r_res;
        map_we = 1'b0; map_waddr = a_key; map_wdata = '0; map_raddr = a_key;
        slot_we = 1'b0; slot_waddr = r_s; slot_wdata = r_srec; slot_raddr = r_s;
        upd = slot_rdata;

        unique case (r_state)
            S_CLEAR: begin
                map_we = 1'b1;
                map_waddr = r_clr;
                n_clr = r_clr + AW'(1);
                if (&r_clr) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op = t_op'(i_operation);
                    n_key = i_key; n_meta = i_is_meta; n_len = i_length; n_now = i_now;
                    unique case (t_op'(i_operation)) inside
                        OP_STORE:                 n_state = S_EV_CHECK;
                        OP_FETCH, OP_INVALIDATE: n_state = S_LK0;
                        default:                  n_state = S_RESP;
                    endcase
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_emit = 1'b1;
                    n_res = '0;
                    n_res.status = 1'b1;
                    n_res.key_out = r_key;
                    n_res.last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_LK0: n_state = S_LK1;
            S_LK1: begin
                slot_raddr = map_rdata;
                n_s = map_rdata;
                n_state = map_hit ? S_LK2 : S_RESP;
            end
            S_LK2: begin
                upd.uses  = slot_rdata.uses + 16'd1;
                upd.stamp = r_now;
                if (slot_rdata.key != r_key) begin
                    n_state = S_RESP;
                end else if (r_op == OP_FETCH) begin
                    slot_we = 1'b1;
                    slot_wdata = upd;
                    n_srec = upd;
                    n_state = S_LK3;
                end else begin
                    n_srec = slot_rdata;
                    n_state = S_LK3;
                end
            end
            S_LK3: begin
                if (out_free) begin
                    n_emit = 1'b1;
                    n_res = '0;
                    n_res.key_out = r_key;
                    n_res.slot = s_wide[9:0];
                    n_res.data_bytes = r_srec.data_bytes;
                    n_res.meta_bytes = r_srec.meta_bytes;
                    n_res.uses = r_srec.uses;
                    n_res.last = 1'b1;
                    n_evict = 1'b0;
                    n_state = (r_op == OP_FETCH) ? S_IDLE : S_RM0;
                end
            end
            S_EV_CHECK: begin
                n_count = '0; n_removed = '0; n_capped = 1'b0;
                n_state = (r_total >= r_byte_limit || r_nfs >= full_lim) ? S_EV_HEAD : S_INS0;
            end
            S_EV_HEAD: begin
                n_pv = 1'b0;
                n_idx = (EB+1)'(1);
                if (r_nfs <= (EB+1)'(1)) begin
                    n_state = S_INS0;
                end else if (r_count == 6'(EVICT_MAX)) begin
                    n_capped = 1'b1;
                    n_state = S_INS0;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // read one slot a cycle, compare the one read the cycle before
                slot_raddr = r_idx[EB-1:0];
                if (r_pv && better) begin
                    n_s = r_pidx;
                    n_srec = slot_rdata;
                end
                n_pv = 1'b1;
                n_pidx = r_idx[EB-1:0];
                n_idx = r_idx + (EB+1)'(1);
                if (r_idx == r_nfs - (EB+1)'(1)) n_state = S_SCAN_END;
            end
            S_SCAN_END: begin
                if (better) begin
                    n_s = r_pidx;
                    n_srec = slot_rdata;
                end
                n_state = S_EV_EMIT;
            end
            S_EV_EMIT: begin
                if (out_free) begin
                    n_emit = 1'b1;
                    n_res = '0;
                    n_res.kind = 1'b1;
                    n_res.key_out = r_srec.key;
                    n_res.slot = s_wide[9:0];
                    n_res.data_bytes = r_srec.data_bytes;
                    n_res.meta_bytes = r_srec.meta_bytes;
                    n_res.uses = r_srec.uses;
                    n_removed = r_removed + TOTAL_W'(r_srec.data_bytes)
                                          + TOTAL_W'(r_srec.meta_bytes);
                    n_evict = 1'b1;
                    n_state = S_RM0;
                end
            end
            S_RM0: begin
                map_raddr = a_skey;
                slot_raddr = last_slot;
                n_state = S_RM1;
            end
            S_RM1: begin
                if (map_rdata == r_s) begin
                    map_we = 1'b1;
                    map_waddr = a_skey;
                    map_wdata = '0;
                end
                n_lrec = slot_rdata;
                n_total = r_total - TOTAL_W'(r_srec.data_bytes)
                                  - TOTAL_W'(r_srec.meta_bytes);
                n_nfs = r_nfs - (EB+1)'(1);
                if (r_s != last_slot) begin
                    slot_we = 1'b1;
                    slot_wdata = slot_rdata;
                    n_state = S_RM2;
                end else begin
                    n_state = S_RM_DONE;
                end
            end
            S_RM2: begin
                map_raddr = a_lkey;
                n_state = S_RM3;
            end
            S_RM3: begin
                // redirect the moved entry's map cell if it named the old slot
                if (map_rdata == r_nfs[EB-1:0]) begin
                    map_we = 1'b1;
                    map_waddr = a_lkey;
                    map_wdata = r_s;
                end
                n_state = S_RM_DONE;
            end
            S_RM_DONE: begin
                if (!r_evict) begin
                    n_state = S_IDLE;
                end else begin
                    n_count = r_count + 6'd1;
                    n_state = (r_removed > r_evict_margin) ? S_INS0 : S_EV_HEAD;
                end
            end
            S_INS0: n_state = S_INS1;
            S_INS1: begin
                n_rep = map_hit;
                n_s = map_hit ? map_rdata : r_nfs[EB-1:0];
                slot_raddr = n_s;
                n_state = S_INS2;
            end
            S_INS2: begin
                upd.key = r_key;
                upd.uses = 16'd1;
                upd.stamp = r_now;
                if (r_meta) begin
                    upd.meta_bytes = r_len;
                    upd.data_bytes = r_rep ? slot_rdata.data_bytes : 32'd0;
                end else begin
                    upd.data_bytes = r_len;
                    upd.meta_bytes = r_rep ? slot_rdata.meta_bytes : 32'd0;
                end
                if (r_rep) begin
                    n_total = r_total + TOTAL_W'(r_len) - TOTAL_W'(r_meta ?
                              slot_rdata.meta_bytes : slot_rdata.data_bytes);
                end else begin
                    n_total = r_total + TOTAL_W'(r_len);
                    n_nfs = r_nfs + (EB+1)'(1);
                    map_we = 1'b1;
                    map_waddr = a_key;
                    map_wdata = r_s;
                end
                slot_we = 1'b1;
                slot_wdata = upd;
                n_srec = upd;
                n_state = S_INS3;
            end
            S_INS3: begin
                if (out_free) begin
                    n_emit = 1'b1;
                    n_res = '0;
                    n_res.key_out = r_key;
                    n_res.slot = s_wide[9:0];
                    n_res.data_bytes = r_srec.data_bytes;
                    n_res.meta_bytes = r_srec.meta_bytes;
                    n_res.uses = r_srec.uses;
                    n_res.evict_capped = r_capped;
                    n_res.last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_nfs <= (EB+1)'(1);
            r_total <= '0;
            r_ov <= 1'b0;
            r_byte_limit <= '0;
            r_evict_margin <= '0;
            r_address_bits <= 4'd12;
            r_capacity_bits <= 4'd10;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_nfs <= n_nfs;
            r_total <= n_total;
            if (n_emit) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_BYTE_LIMIT:    r_byte_limit <= i_cfg_data;
                    CFG_EVICT_MARGIN:  r_evict_margin <= i_cfg_data;
                    CFG_ADDRESS_BITS:  r_address_bits <= i_cfg_data[3:0];
                    CFG_CAPACITY_BITS: r_capacity_bits <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_key <= n_key; r_len <= n_len; r_now <= n_now; r_meta <= n_meta;
        r_idx <= n_idx; r_pidx <= n_pidx; r_pv <= n_pv; r_s <= n_s;
        r_srec <= n_srec; r_lrec <= n_lrec; r_count <= n_count; r_removed <= n_removed;
        r_capped <= n_capped; r_rep <= n_rep; r_evict <= n_evict;
        r_res <= n_res;
    end

    assign o_out_valid    = r_ov;
    assign o_kind         = r_res.kind;
    assign o_status       = r_res.status;
    assign o_key_out      = r_res.key_out;
    assign o_slot         = r_res.slot;
    assign o_data_bytes   = r_res.data_bytes;
    assign o_meta_bytes   = r_res.meta_bytes;
    assign o_uses         = r_res.uses;
    assign o_evict_capped = r_res.evict_capped;
    assign o_last         = r_res.last;
endmodule

// ===== src/cit_checker.sv =====
// Port-level checks for the cache index table, bound to the top level.
module cit_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic                      o_kind,
    input logic                      o_status,
    input logic [31:0]               o_key_out,
    input logic [9:0]                o_slot,
    input logic [31:0]               o_data_bytes,
    input logic [31:0]               o_meta_bytes,
    input logic [15:0]               o_uses,
    input logic                      o_evict_capped,
    input logic                      o_last
);
    // notices are never final, answers always are
    a_kind_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_kind != o_last))
        else $error("kind and last disagree");

    a_miss_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (!o_kind && o_slot == 10'd0 && o_uses == 16'd0
                                       && o_data_bytes == 32'd0 && o_meta_bytes == 32'd0))
        else $error("miss carries entry fields");

    a_notice_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind) |-> (!o_evict_capped && !o_status))
        else $error("eviction notice with capped or miss flag");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_key_out)
                                          && $stable(o_last)))
        else $error("stalled item changed");
endmodule

bind cache_index_table_with_lfu_eviction_core cit_checker u_cit_checker (.*);
